### rtl/core/usart_pkg.sv
package usart_pkg;

  // Request codes on the command field.
  localparam logic [2:0] CmdBusWrite = 3'd0;
  localparam logic [2:0] CmdBusRead  = 3'd1;
  localparam logic [2:0] CmdLineByte = 3'd2;
  localparam logic [2:0] CmdRxDone   = 3'd3;
  localparam logic [2:0] CmdTxDone   = 3'd4;

  // Bus address bit.
  localparam logic PortData    = 1'b0;
  localparam logic PortControl = 1'b1;

  // Control write sequence.
  localparam logic [1:0] PhMode  = 2'd0;
  localparam logic [1:0] PhSync1 = 2'd1;
  localparam logic [1:0] PhSync2 = 2'd2;
  localparam logic [1:0] PhCmd   = 2'd3;

  // Status bit positions.
  localparam int unsigned StTxRdy   = 0;
  localparam int unsigned StRxRdy   = 1;
  localparam int unsigned StTxEmpty = 2;
  localparam int unsigned StOverrun = 4;
  localparam logic [6:0]  StErrMask = 7'h38;
  localparam logic [6:0]  StReset   = 7'h05;

  // Command bit positions.
  localparam int unsigned CmTxEn   = 0;
  localparam int unsigned CmDtr    = 1;
  localparam int unsigned CmRxEn   = 2;
  localparam int unsigned CmRstErr = 4;
  localparam int unsigned CmRts    = 5;
  localparam int unsigned CmReset  = 6;

  // Baud rate factor codes in mode bits 1:0.
  localparam logic [1:0] RateSync = 2'd0;
  localparam logic [1:0] RateX1   = 2'd1;
  localparam logic [1:0] RateX16  = 2'd2;
  localparam logic [1:0] RateX64  = 2'd3;

  localparam int unsigned CharLenWidth = 10;

endpackage

### rtl/core/usart_char_time.sv
module usart_char_time (
  input  logic [7:0]                           mode_i,
  output logic [usart_pkg::CharLenWidth-1:0]   char_length_o
);

  // Half-bit count of one character: start, data, parity and stop bits.
  logic [4:0] half_bits;
  logic [4:0] stop_half;

  always_comb begin
    case (mode_i[7:6])
      2'd0:    stop_half = 5'd0;
      2'd1:    stop_half = 5'd2;
      2'd2:    stop_half = 5'd3;
      default: stop_half = 5'd4;
    endcase
    half_bits = 5'd12 + {2'b00, mode_i[3:2], 1'b0} + {3'b000, mode_i[4], 1'b0} + stop_half;
  end

  // The result is half_bits * rate / 2, so the rate factor becomes a shift.
  always_comb begin
    case (mode_i[1:0])
      usart_pkg::RateSync,
      usart_pkg::RateX1:  char_length_o = {6'd0, half_bits[4:1]};
      usart_pkg::RateX16: char_length_o = {2'd0, half_bits, 3'd0};
      usart_pkg::RateX64: char_length_o = {half_bits, 5'd0};
      default:            char_length_o = '0;
    endcase
  end

endmodule

### rtl/core/usart_register_interface.sv
// The result of a request is registered, loaded at the same edge that accepts the request.
// Throughput: one request per cycle; the result register lets a new request in while the
// current result is taken, so only a stalled result holds off the input.
// Reset (rst_ni low, asynchronous): control phase back to mode, the other state registers
// cleared, status reads transmitter ready and empty, and no result is pending.
module usart_register_interface (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           command_i,
  input  logic                                 port_i,
  input  logic [7:0]                           data_i,
  input  logic                                 dsr_line_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [7:0]                           read_data_o,
  output logic [7:0]                           tx_byte_o,
  output logic                                 tx_valid_o,
  output logic                                 tx_timer_start_o,
  output logic                                 tx_timer_cancel_o,
  output logic                                 rx_timer_start_o,
  output logic                                 rx_timer_cancel_o,
  output logic [usart_pkg::CharLenWidth-1:0]   char_length_o,
  output logic                                 rts_line_o,
  output logic                                 dtr_line_o,
  output logic                                 rx_ready_line_o,
  output logic                                 recv_signal_o
);

  // Register file of the USART. The sync characters are written as part of the control
  // sequence, but since sync detection is not modeled their values are never needed and
  // they are not kept.
  logic [1:0]                          phase_q, phase_d;
  logic [7:0]                          mode_q, mode_d;
  logic [7:0]                          cmd_q, cmd_d;
  logic [6:0]                          status_q, status_d;
  logic [7:0]                          rx_buf_q, rx_buf_d;
  logic                                rx_wait_q, rx_wait_d;
  logic [7:0]                          shift_q, shift_d;
  logic [7:0]                          hold_q, hold_d;
  logic [usart_pkg::CharLenWidth-1:0]  char_len_q, char_len_d;
  logic                                rx_pin_q, rx_pin_d;

  // Result of the request being accepted this cycle.
  logic [7:0] rd_data;
  logic [7:0] tx_byte;
  logic       tx_vld, tx_start, tx_cancel, rx_start, rx_cancel, recv_sig;

  // Character time that a mode write with the current bus byte would set.
  logic [usart_pkg::CharLenWidth-1:0] new_char_len;

  logic accept;
  logic out_valid_q;

  usart_char_time u_char_time (
    .mode_i        (data_i),
    .char_length_o (new_char_len)
  );

  // The result register frees up when it is empty or being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    mode_d     = mode_q;
    cmd_d      = cmd_q;
    status_d   = status_q;
    rx_buf_d   = rx_buf_q;
    rx_wait_d  = rx_wait_q;
    shift_d    = shift_q;
    hold_d     = hold_q;
    char_len_d = char_len_q;
    rx_pin_d   = rx_pin_q;

    rd_data   = 8'd0;
    tx_byte   = 8'd0;
    tx_vld    = 1'b0;
    tx_start  = 1'b0;
    tx_cancel = 1'b0;
    rx_start  = 1'b0;
    rx_cancel = 1'b0;
    recv_sig  = 1'b0;

    case (command_i)
      usart_pkg::CmdBusWrite: begin
        if (port_i == usart_pkg::PortData) begin
          // With TX enabled, a data write goes to an idle shifter, else to the holding byte.
          if (cmd_q[usart_pkg::CmTxEn]) begin
            if (status_q[usart_pkg::StTxEmpty]) begin
              status_d[usart_pkg::StTxEmpty] = 1'b0;
              shift_d  = data_i;
              tx_start = 1'b1;
            end else begin
              hold_d = data_i;
              status_d[usart_pkg::StTxRdy] = 1'b0;
            end
          end
        end else begin
          case (phase_q)
            usart_pkg::PhMode: begin
              mode_d     = data_i;
              char_len_d = new_char_len;
              // Synchronous mode (rate code zero) expects sync characters next.
              phase_d = (data_i[1:0] == usart_pkg::RateSync) ? usart_pkg::PhSync1
                                                             : usart_pkg::PhCmd;
            end
            usart_pkg::PhSync1: begin
              // Mode bit 7 selects a single sync character in synchronous mode.
              phase_d = mode_q[7] ? usart_pkg::PhCmd : usart_pkg::PhSync2;
            end
            usart_pkg::PhSync2: begin
              phase_d = usart_pkg::PhCmd;
            end
            default: begin
              if (data_i[usart_pkg::CmReset]) begin
                // An internal reset only rewinds the control sequence.
                phase_d = usart_pkg::PhMode;
              end else begin
                cmd_d = data_i;
                if (!data_i[usart_pkg::CmTxEn]) begin
                  tx_cancel = 1'b1;
                  status_d[usart_pkg::StTxRdy]   = 1'b1;
                  status_d[usart_pkg::StTxEmpty] = 1'b1;
                end
                if (data_i[usart_pkg::CmRstErr]) begin
                  status_d = status_d & ~usart_pkg::StErrMask;
                end
                // Toggling the receive enable clears errors and tells the line side.
                if (data_i[usart_pkg::CmRxEn] != cmd_q[usart_pkg::CmRxEn]) begin
                  status_d = status_d & ~usart_pkg::StErrMask;
                  if (data_i[usart_pkg::CmRxEn]) begin
                    rx_wait_d = 1'b1;
                  end else begin
                    rx_cancel = 1'b1;
                    status_d[usart_pkg::StRxRdy] = 1'b0;
                  end
                  recv_sig = 1'b1;
                end
              end
            end
          endcase
        end
      end
      usart_pkg::CmdBusRead: begin
        if (port_i == usart_pkg::PortData) begin
          status_d[usart_pkg::StRxRdy] = 1'b0;
          rx_pin_d = 1'b0;
          rd_data  = rx_buf_q;
        end else begin
          rd_data = {dsr_line_i, status_q};
        end
      end
      usart_pkg::CmdLineByte: begin
        if (rx_wait_q && cmd_q[usart_pkg::CmRxEn]) begin
          // A byte landing on an unread buffer is dropped and flagged as overrun.
          if (status_q[usart_pkg::StRxRdy]) begin
            status_d[usart_pkg::StOverrun] = 1'b1;
          end else begin
            rx_buf_d = data_i;
            status_d[usart_pkg::StRxRdy] = 1'b1;
            rx_pin_d = 1'b1;
          end
          rx_wait_d = 1'b0;
          rx_start  = 1'b1;
        end
      end
      usart_pkg::CmdRxDone: begin
        if (cmd_q[usart_pkg::CmRxEn]) begin
          rx_wait_d = 1'b1;
          recv_sig  = 1'b1;
        end
      end
      usart_pkg::CmdTxDone: begin
        if (!status_q[usart_pkg::StTxEmpty] && cmd_q[usart_pkg::CmTxEn]) begin
          tx_byte = shift_q;
          tx_vld  = 1'b1;
          // Either the line goes idle or the holding byte moves into the shifter.
          if (status_q[usart_pkg::StTxRdy]) begin
            status_d[usart_pkg::StTxEmpty] = 1'b1;
          end else begin
            status_d[usart_pkg::StTxRdy]   = 1'b1;
            status_d[usart_pkg::StTxEmpty] = 1'b0;
            shift_d  = hold_q;
            tx_start = 1'b1;
          end
        end
      end
      default: begin
        // Unknown codes leave the state alone and report the line levels only.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= usart_pkg::PhMode;
      mode_q     <= '0;
      cmd_q      <= '0;
      status_q   <= usart_pkg::StReset;
      rx_buf_q   <= '0;
      rx_wait_q  <= 1'b0;
      shift_q    <= '0;
      hold_q     <= '0;
      char_len_q <= '0;
      rx_pin_q   <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      mode_q     <= mode_d;
      cmd_q      <= cmd_d;
      status_q   <= status_d;
      rx_buf_q   <= rx_buf_d;
      rx_wait_q  <= rx_wait_d;
      shift_q    <= shift_d;
      hold_q     <= hold_d;
      char_len_q <= char_len_d;
      rx_pin_q   <= rx_pin_d;
    end
  end

  // Result register: the valid flag is reset, the payload is simply loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_data_o       <= rd_data;
      tx_byte_o         <= tx_byte;
      tx_valid_o        <= tx_vld;
      tx_timer_start_o  <= tx_start;
      tx_timer_cancel_o <= tx_cancel;
      rx_timer_start_o  <= rx_start;
      rx_timer_cancel_o <= rx_cancel;
      char_length_o     <= char_len_d;
      rts_line_o        <= cmd_d[usart_pkg::CmRts];
      dtr_line_o        <= cmd_d[usart_pkg::CmDtr];
      rx_ready_line_o   <= rx_pin_d;
      recv_signal_o     <= recv_sig;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Request codes above the defined range; the block must treat them as no-ops.
  localparam logic [2:0] CmdSpare5 = 3'd5;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  // Command words used by the directed part. The all-on word enables both
  // directions, raises DTR and RTS and clears the error flags.
  localparam logic [7:0] CmdWordAllOn = 8'((1 << usart_pkg::CmTxEn) | (1 << usart_pkg::CmDtr) |
                                           (1 << usart_pkg::CmRxEn) |
                                           (1 << usart_pkg::CmRstErr) |
                                           (1 << usart_pkg::CmRts));
  localparam logic [7:0] CmdWordReset = 8'(1 << usart_pkg::CmReset);
  localparam logic [7:0] CmdWordOff   = 8'h00;

  // A correct run never goes this many cycles without a handshake on either side.
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomItems = 1950;

  typedef struct packed {
    logic [2:0] command;
    logic       port;
    logic [7:0] data;
    logic       dsr;
  } usart_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       tx_start;
    logic       tx_cancel;
    logic       rx_start;
    logic       rx_cancel;
    logic [9:0] char_len;
    logic       rts;
    logic       dtr;
    logic       rx_pin;
    logic       recv_sig;
  } usart_res_t;

  // Everything the register model keeps between requests.
  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] mode;
    logic [7:0] sync1;
    logic [7:0] sync2;
    logic [7:0] cmd_word;
    logic [6:0] status;
    logic [7:0] rx_buf;
    logic       rx_wait;
    logic [7:0] shift;
    logic [7:0] hold;
    logic [9:0] char_len;
    logic       rx_pin;
  } usart_state_t;

  typedef struct {
    usart_req_t rq;
    bit         typed;
    logic [7:0] rd;
    logic [9:0] ln;
  } dir_row_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] command_i  = '0;
  logic       port_i     = 1'b0;
  logic [7:0] data_i     = '0;
  logic       dsr_line_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] read_data_o;
  logic [7:0] tx_byte_o;
  logic       tx_valid_o;
  logic       tx_timer_start_o;
  logic       tx_timer_cancel_o;
  logic       rx_timer_start_o;
  logic       rx_timer_cancel_o;
  logic [usart_pkg::CharLenWidth-1:0] char_length_o;
  logic       rts_line_o;
  logic       dtr_line_o;
  logic       rx_ready_line_o;
  logic       recv_signal_o;

  // Side channel that travels with the request being driven: for a few directed
  // rows the read value and character time are typed in by hand.
  bit         drv_typed = 1'b0;
  logic [7:0] drv_read  = '0;
  logic [9:0] drv_len   = '0;

  usart_state_t model_state;   // advanced when the block accepts a request
  usart_state_t plan_state;    // advanced by the stimulus side to steer sequences
  usart_res_t   pending_results[$];
  dir_row_t     dir_rows[$];
  int unsigned  fail_count  = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left  = 0;

  usart_register_interface dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic usart_state_t usart_reset_state();
    usart_state_t s;
    s = '0;
    s.phase  = usart_pkg::PhMode;
    s.status = usart_pkg::StReset;
    return s;
  endfunction

  // One request through the register model. The state is updated in place;
  // the line levels and the character time are then read from the state.
  function automatic void usart_step(inout usart_state_t s, input usart_req_t rq,
                                     output usart_res_t rs);
    logic [7:0]  old_cmd;
    int unsigned bits;
    int unsigned half_stops;
    int unsigned rate;
    rs = '0;
    case (rq.command)
      usart_pkg::CmdBusWrite: begin
        if (rq.port == usart_pkg::PortData) begin
          // Data writes only count while the transmitter is enabled. An empty
          // transmitter starts sending at once, otherwise the byte waits.
          if (s.cmd_word[usart_pkg::CmTxEn]) begin
            if (s.status[usart_pkg::StTxEmpty]) begin
              s.status[usart_pkg::StTxEmpty] = 1'b0;
              s.shift = rq.data;
              rs.tx_start = 1'b1;
            end else begin
              s.hold = rq.data;
              s.status[usart_pkg::StTxRdy] = 1'b0;
            end
          end
        end else begin
          case (s.phase)
            usart_pkg::PhMode: begin
              s.mode = rq.data;
              bits = 5 + rq.data[3:2];
              case (rq.data[7:6])
                2'd0:    half_stops = 0;
                2'd1:    half_stops = 2;
                2'd2:    half_stops = 3;
                default: half_stops = 4;
              endcase
              case (rq.data[1:0])
                usart_pkg::RateX16: rate = 16;
                usart_pkg::RateX64: rate = 64;
                default:            rate = 1;
              endcase
              s.char_len = 10'(((2 * (1 + bits + rq.data[4]) + half_stops) * rate) / 2);
              s.phase = (rq.data[1:0] == usart_pkg::RateSync) ? usart_pkg::PhSync1
                                                               : usart_pkg::PhCmd;
            end
            usart_pkg::PhSync1: begin
              s.sync1 = rq.data;
              s.phase = s.mode[7] ? usart_pkg::PhCmd : usart_pkg::PhSync2;
            end
            usart_pkg::PhSync2: begin
              s.sync2 = rq.data;
              s.phase = usart_pkg::PhCmd;
            end
            default: begin
              if (rq.data[usart_pkg::CmReset]) begin
                s.phase = usart_pkg::PhMode;
              end else begin
                old_cmd = s.cmd_word;
                s.cmd_word = rq.data;
                if (!rq.data[usart_pkg::CmTxEn]) begin
                  rs.tx_cancel = 1'b1;
                  s.status[usart_pkg::StTxRdy] = 1'b1;
                  s.status[usart_pkg::StTxEmpty] = 1'b1;
                end
                if (rq.data[usart_pkg::CmRstErr]) s.status = s.status & ~usart_pkg::StErrMask;
                // Any change of the receive enable clears the errors and is
                // signalled to the line side.
                if (rq.data[usart_pkg::CmRxEn] != old_cmd[usart_pkg::CmRxEn]) begin
                  s.status = s.status & ~usart_pkg::StErrMask;
                  if (rq.data[usart_pkg::CmRxEn]) begin
                    s.rx_wait = 1'b1;
                  end else begin
                    rs.rx_cancel = 1'b1;
                    s.status[usart_pkg::StRxRdy] = 1'b0;
                  end
                  rs.recv_sig = 1'b1;
                end
              end
            end
          endcase
        end
      end
      usart_pkg::CmdBusRead: begin
        if (rq.port == usart_pkg::PortData) begin
          s.status[usart_pkg::StRxRdy] = 1'b0;
          s.rx_pin = 1'b0;
          rs.read_data = s.rx_buf;
        end else begin
          rs.read_data = {rq.dsr, s.status};
        end
      end
      usart_pkg::CmdLineByte: begin
        if (s.rx_wait && s.cmd_word[usart_pkg::CmRxEn]) begin
          // A byte that finds the buffer still full is lost and flags overrun.
          if (s.status[usart_pkg::StRxRdy]) begin
            s.status[usart_pkg::StOverrun] = 1'b1;
          end else begin
            s.rx_buf = rq.data;
            s.status[usart_pkg::StRxRdy] = 1'b1;
            s.rx_pin = 1'b1;
          end
          s.rx_wait = 1'b0;
          rs.rx_start = 1'b1;
        end
      end
      usart_pkg::CmdRxDone: begin
        if (s.cmd_word[usart_pkg::CmRxEn]) begin
          s.rx_wait = 1'b1;
          rs.recv_sig = 1'b1;
        end
      end
      usart_pkg::CmdTxDone: begin
        if (!s.status[usart_pkg::StTxEmpty] && s.cmd_word[usart_pkg::CmTxEn]) begin
          rs.tx_byte = s.shift;
          rs.tx_valid = 1'b1;
          if (s.status[usart_pkg::StTxRdy]) begin
            s.status[usart_pkg::StTxEmpty] = 1'b1;
          end else begin
            // The holding byte moves on into the shifter right away.
            s.status[usart_pkg::StTxRdy] = 1'b1;
            s.shift = s.hold;
            rs.tx_start = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rs.char_len = s.char_len;
    rs.rts      = s.cmd_word[usart_pkg::CmRts];
    rs.dtr      = s.cmd_word[usart_pkg::CmDtr];
    rs.rx_pin   = s.rx_pin;
  endfunction

  // Random command word without the sequence reset bit. Most words enable
  // both directions so that traffic gets through.
  function automatic logic [7:0] rand_command();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    v[usart_pkg::CmReset] = 1'b0;
    if ($urandom_range(0, 4) != 0) begin
      v[usart_pkg::CmTxEn] = 1'b1;
      v[usart_pkg::CmRxEn] = 1'b1;
    end
    return v;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic port, input logic [7:0] data,
                                  input logic dsr, input bit typed, input logic [7:0] rd,
                                  input logic [9:0] ln);
    dir_row_t r;
    r.rq    = '{command: cmd, port: port, data: data, dsr: dsr};
    r.typed = typed;
    r.rd    = rd;
    r.ln    = ln;
    dir_rows.push_back(r);
  endfunction

  // Drives one request and returns at the clock edge that accepts it. The
  // sender works in bursts; at the end of a burst valid drops for a random gap.
  task automatic send_req(input usart_req_t rq, input bit typed, input logic [7:0] rd,
                          input logic [9:0] ln);
    usart_res_t  unused;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= rq.command;
    port_i     <= rq.port;
    data_i     <= rq.data;
    dsr_line_i <= rq.dsr;
    drv_typed  <= typed;
    drv_read   <= rd;
    drv_len    <= ln;
    // Everything settles between edges, so ready is judged at the falling edge.
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    usart_step(plan_state, rq, unused);
  endtask

  // The receiver switches between stall patterns: always ready, ready most of
  // the time, ready in a regular repeating pattern, or long random holds.
  int unsigned rx_cycle  = 0;
  int unsigned rx_mode   = 0;
  int unsigned rx_hold   = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 9) < 7);
      2: out_ready_i <= (rx_cycle % 3 == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 20);
          out_ready_i <= ~out_ready_i;
        end else begin
          rx_hold--;
        end
      end
    endcase
  end

  // Both handshakes are observed at the falling edge, where the values that
  // the next rising edge will act on are stable. Results are checked first;
  // a request seen here is accepted at the coming edge, so its result can
  // only appear later.
  always @(negedge clk_i) begin
    usart_res_t want;
    usart_res_t got;
    usart_req_t cur;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{read_data: read_data_o, tx_byte: tx_byte_o, tx_valid: tx_valid_o,
                tx_start: tx_timer_start_o, tx_cancel: tx_timer_cancel_o,
                rx_start: rx_timer_start_o, rx_cancel: rx_timer_cancel_o,
                char_len: char_length_o, rts: rts_line_o, dtr: dtr_line_o,
                rx_pin: rx_ready_line_o, recv_sig: recv_signal_o};
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual 0x%0h",
                   $time, got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("tx_valid", want.tx_valid, got.tx_valid);
          check_field("tx_timer_start", want.tx_start, got.tx_start);
          check_field("tx_timer_cancel", want.tx_cancel, got.tx_cancel);
          check_field("rx_timer_start", want.rx_start, got.rx_start);
          check_field("rx_timer_cancel", want.rx_cancel, got.rx_cancel);
          check_field("char_length", want.char_len, got.char_len);
          check_field("rts_line", want.rts, got.rts);
          check_field("dtr_line", want.dtr, got.dtr);
          check_field("rx_ready_line", want.rx_pin, got.rx_pin);
          check_field("recv_signal", want.recv_sig, got.recv_sig);
        end
      end
      if (in_valid_i && in_ready_o) begin
        cur = '{command: command_i, port: port_i, data: data_i, dsr: dsr_line_i};
        usart_step(model_state, cur, want);
        if (drv_typed) begin
          want.read_data = drv_read;
          want.char_len  = drv_len;
        end
        pending_results.push_back(want);
      end
      // Watchdog: a stuck handshake on either side ends the run.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
          $display("** usart_register_interface: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    usart_req_t  rq;
    int unsigned kind;
    int unsigned counted;
    bit          need_cmd;
    model_state = usart_reset_state();
    plan_state  = usart_reset_state();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Typed rows carry values that follow directly from reset,
    // the slowest mode, the overrun case and the shortest synchronous mode.
    add_row(usart_pkg::CmdBusRead,  usart_pkg::PortControl, 8'h00, 1'b0, 1'b1, 8'h05, 10'd0);
    add_row(usart_pkg::CmdBusRead,  usart_pkg::PortControl, 8'hFF, 1'b1, 1'b1, 8'h85, 10'd0);
    add_row(usart_pkg::CmdBusRead,  usart_pkg::PortData,    8'h00, 1'b0, 1'b1, 8'h00, 10'd0);
    // Everything below is ignored while both directions are disabled.
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortData,    8'hFF, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdTxDone,   usart_pkg::PortData,    8'h00, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdLineByte, usart_pkg::PortData,    8'h3C, 1'b1, 1'b0, '0, '0);
    add_row(usart_pkg::CmdRxDone,   usart_pkg::PortData,    8'h00, 1'b0, 1'b0, '0, '0);
    add_row(CmdSpare5,              usart_pkg::PortControl, 8'hFF, 1'b1, 1'b0, '0, '0);
    add_row(CmdSpare7,              usart_pkg::PortData,    8'h00, 1'b0, 1'b0, '0, '0);
    // Eight bits, parity, two stop bits at x64 gives the longest character.
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortControl, 8'hFF, 1'b0, 1'b1, 8'h00, 10'd768);
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortControl, CmdWordAllOn, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdLineByte, usart_pkg::PortData,    8'hA5, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdRxDone,   usart_pkg::PortData,    8'h00, 1'b0, 1'b0, '0, '0);
    // Second byte while the first is unread: dropped, overrun flagged.
    add_row(usart_pkg::CmdLineByte, usart_pkg::PortData,    8'h5A, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdBusRead,  usart_pkg::PortControl, 8'h00, 1'b0, 1'b1, 8'h17, 10'd768);
    add_row(usart_pkg::CmdBusRead,  usart_pkg::PortData,    8'h00, 1'b0, 1'b1, 8'hA5, 10'd768);
    // Fill the shifter and the holding byte, then drain both.
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortData,    8'h00, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortData,    8'hFF, 1'b1, 1'b0, '0, '0);
    add_row(usart_pkg::CmdTxDone,   usart_pkg::PortData,    8'h00, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdTxDone,   usart_pkg::PortData,    8'h00, 1'b0, 1'b0, '0, '0);
    // Back to the mode phase, then a synchronous mode with two sync bytes.
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortControl, CmdWordReset, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortControl, 8'h00, 1'b0, 1'b1, 8'h00, 10'd6);
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortControl, 8'hAA, 1'b0, 1'b0, '0, '0);
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortControl, 8'h55, 1'b0, 1'b0, '0, '0);
    // Disabling both directions cancels both timers.
    add_row(usart_pkg::CmdBusWrite, usart_pkg::PortControl, CmdWordOff, 1'b1, 1'b0, '0, '0);

    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rd,
                                   dir_rows[i].ln);

    // Random part. The plan state tells where the control sequence stands, so
    // most requests finish a setup sequence or move traffic once enabled.
    counted  = 0;
    need_cmd = 1'b1;
    while (counted < RandomItems) begin
      kind = $urandom_range(0, 99);
      rq = '{command: usart_pkg::CmdBusWrite, port: usart_pkg::PortControl,
             data: 8'($urandom_range(0, 255)), dsr: 1'($urandom_range(0, 1))};
      if (plan_state.phase != usart_pkg::PhCmd && kind < 85) begin
        // Mode or sync byte with random content.
        need_cmd = 1'b1;
      end else if (need_cmd && plan_state.phase == usart_pkg::PhCmd) begin
        rq.data  = rand_command();
        need_cmd = 1'b0;
      end else if (kind < 4) begin
        // Sequence reset; the other bits of the word must not matter.
        rq.data[usart_pkg::CmReset] = 1'b1;
        need_cmd = 1'b1;
      end else if (kind < 8) begin
        rq.data = rand_command();
      end else if (kind < 28) begin
        rq.port = usart_pkg::PortData;
      end else if (kind < 48) begin
        rq.command = usart_pkg::CmdTxDone;
        rq.port    = 1'($urandom_range(0, 1));
      end else if (kind < 63) begin
        rq.command = usart_pkg::CmdLineByte;
        rq.port    = 1'($urandom_range(0, 1));
      end else if (kind < 75) begin
        rq.command = usart_pkg::CmdRxDone;
        rq.port    = 1'($urandom_range(0, 1));
      end else if (kind < 87) begin
        rq.command = usart_pkg::CmdBusRead;
        rq.port    = 1'($urandom_range(0, 1));
      end else begin
        // Noise: any code, any port, any byte.
        rq.command = 3'($urandom_range(0, 7));
        rq.port    = 1'($urandom_range(0, 1));
      end
      counted++;
      send_req(rq, 1'b0, '0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** usart_register_interface: PASSED **");
    end else begin
      $display("** usart_register_interface: FAILED **");
    end
    $finish;
  end

endmodule
